// ----- rtl/assert_macros.svh -----
// Assertion macros used by the frame generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- rtl/lpfg_pkg.sv -----
// ---------------------------------------------------------------------------
// lpfg_pkg: shared types and constants of the LED pattern frame generator.
// Holds mode and register codes, and the breathing brightness table.
// ---------------------------------------------------------------------------
package lpfg_pkg;

   typedef enum logic [2:0] {
      MODE_STATIC  = 3'd0,
      MODE_RAINBOW = 3'd1,
      MODE_BREATH  = 3'd2,
      MODE_CHASE   = 3'd3,
      MODE_SPARKLE = 3'd4,
      MODE_CYCLE   = 3'd5,
      MODE_RSVD6   = 3'd6,
      MODE_RSVD7   = 3'd7
   } mode_type;

   localparam logic [2:0] REG_MODE      = 3'd0;
   localparam logic [2:0] REG_BASE      = 3'd1;
   localparam logic [2:0] REG_SLOTS     = 3'd2;
   localparam logic [2:0] REG_PAL_COUNT = 3'd3;
   localparam logic [2:0] REG_PAL_LOW   = 3'd4;
   localparam logic [2:0] REG_PAL_HIGH  = 3'd5;

   localparam int CSR_DATA_W = 48;
   localparam logic [15:0] LFSR_SEED = 16'hACE1;

   // Brightness for k = 0..60 in Q1.16, smoother-step from 0.1 to 1.0.
   function automatic logic [16:0] breath_level(input logic [5:0] k);
      longint unsigned kk, k3, k4, k5, poly, num;
      kk   = longint'(k);
      k3   = kk * kk * kk;
      k4   = k3 * kk;
      k5   = k4 * kk;
      poly = 6 * k5 + 36000 * k3 - 900 * k4;
      num  = 64'd777600000 + 9 * poly;
      breath_level = 17'((num * 65536 + 64'd3888000000) / 64'd7776000000);
   endfunction

   // The whole brightness curve, entry k in bits 17*k+16 down to 17*k.
   localparam int BREATH_STEPS = 61;

   function automatic logic [BREATH_STEPS*17-1:0] breath_table();
      logic [BREATH_STEPS*17-1:0] t;
      t = '0;
      for (int k = 0; k < BREATH_STEPS; k++) t[k*17 +: 17] = breath_level(6'(k));
      breath_table = t;
   endfunction

   localparam logic [BREATH_STEPS*17-1:0] BREATH_TABLE = breath_table();

endpackage

// ----- rtl/led_pattern_frame_generator.sv -----
// ---------------------------------------------------------------------------
// led_pattern_frame_generator
// On each frame tick, rewrites the colour memory for every slot in use and
// streams the new colours out, one slot per transfer.
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  req_      in         tdata[0] tick
//  rsp_      out        tdata slot, red, green, blue; tlast last slot
//  csr_      in         wr, index, wdata
//
// Per frame, the block first builds the chase head as a bit-serial
// remainder of the frame count, then per slot does a memory read and a
// write back with output, then drains the output register and goes idle.
// A waiting transfer held back by rsp_tready stalls the slot walk. Reset
// is synchronous; the colour memory starts black by per-slot valid bits.
// One tick is taken at a time; a zero tick or a tick in static or a
// reserved mode is taken without starting a frame.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module led_pattern_frame_generator #(
   parameter int SLOT_COUNT_MAX = 32,
   parameter int PALETTE_SIZE   = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] tick
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [4:0] slot, [12:5] red, [20:13] green, [28:21] blue
   output logic        rsp_tlast,   // last slot of the frame
   input  logic        csr_wr,
   input  logic [2:0]  csr_index,
   input  logic [lpfg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lpfg_pkg::*;

   localparam int AW = (SLOT_COUNT_MAX > 1) ? $clog2(SLOT_COUNT_MAX) : 1;
   localparam int NW = $clog2(SLOT_COUNT_MAX + 1);
   localparam int PW = $clog2(PALETTE_SIZE + 1);

   typedef enum logic [2:0] {ST_IDLE, ST_MOD, ST_READ, ST_WRITE, ST_DRAIN} state_type;

   // Configuration registers.
   mode_type    mode_ff;
   logic [23:0] base_ff;
   logic [5:0]  slots_ff;
   logic [2:0]  pal_count_ff;
   logic [47:0] pal_low_ff, pal_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_STATIC;
         base_ff      <= '0;
         slots_ff     <= 6'd32;
         pal_count_ff <= '0;
         pal_low_ff   <= '0;
         pal_high_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_MODE:      mode_ff      <= mode_type'(csr_wdata[2:0]);
            REG_BASE:      base_ff      <= csr_wdata[23:0];
            REG_SLOTS:     slots_ff     <= csr_wdata[5:0];
            REG_PAL_COUNT: pal_count_ff <= csr_wdata[2:0];
            REG_PAL_LOW:   pal_low_ff   <= csr_wdata;
            REG_PAL_HIGH:  pal_high_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Effective slot and palette counts.
   logic [NW-1:0] n_eff;
   logic [PW-1:0] pcnt;
   always_comb begin
      if (slots_ff == 6'd0) n_eff = NW'(1);
      else if (32'(slots_ff) > SLOT_COUNT_MAX) n_eff = NW'(SLOT_COUNT_MAX);
      else n_eff = NW'(slots_ff);
      if (32'(pal_count_ff) > PALETTE_SIZE) pcnt = PW'(PALETTE_SIZE);
      else pcnt = PW'(pal_count_ff);
   end

   // Colour memory with one read and one write port.
   logic [23:0]             mem [SLOT_COUNT_MAX];
   logic [SLOT_COUNT_MAX-1:0] valid_ff;
   logic [23:0]             rd_data_ff;
   logic                    mem_we;
   logic [AW-1:0]           idx_addr;
   logic [23:0]             wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) mem[idx_addr] <= wr_data;
      rd_data_ff <= mem[idx_addr];
   end

   // Frame state.
   state_type     state_ff;
   logic [NW-1:0] idx_ff;
   logic [4:0]    bit_ff;       // frame count bit taken by the remainder
   logic [31:0]   frame_ff;
   logic [15:0]   lfsr_ff;
   logic [8:0]    rb_off_ff;    // 5*(frame mod 72)
   logic [6:0]    br_ff;        // frame mod 120
   logic [NW-1:0] head_ff;      // frame mod n, built one bit per cycle
   logic [4:0]    cyc_sub_ff;   // frame mod 30
   logic [3:0]    cyc_q_ff;     // (frame/30) mod 12
   logic [8:0]    hue_ff;
   logic [23:0]   breath_col_ff;
   logic          out_v_ff;
   logic [4:0]    out_slot_ff;
   logic [23:0]   out_col_ff;
   logic          out_last_ff;

   assign idx_addr = idx_ff[AW-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {3'd0, out_col_ff[7:0], out_col_ff[15:8], out_col_ff[23:16],
                        out_slot_ff};
   assign rsp_tlast  = out_last_ff;

   // Current colour of the slot, black if never written.
   logic [23:0] cur;
   assign cur = valid_ff[idx_addr] ? rd_data_ff : 24'd0;

   // Remainder step: shift in the next frame count bit, subtract n if it fits.
   logic [NW:0]   head_sh;
   logic [NW-1:0] head_nx;
   always_comb begin
      head_sh = {head_ff, frame_ff[bit_ff]};
      head_nx = (head_sh >= {1'b0, n_eff}) ? NW'(head_sh - {1'b0, n_eff}) : NW'(head_sh);
   end

   // Rainbow hue colour; the ramp d*255/60 is d*17/4.
   logic [2:0]  sector;
   logic [5:0]  dd;
   logic [5:0]  rd;
   logic [7:0]  ramp;
   logic [9:0]  rprod;
   logic [23:0] hue_col;
   always_comb begin
      priority if (hue_ff >= 9'd300) begin
         sector = 3'd5;
         dd     = 6'(hue_ff - 9'd300);
      end else if (hue_ff >= 9'd240) begin
         sector = 3'd4;
         dd     = 6'(hue_ff - 9'd240);
      end else if (hue_ff >= 9'd180) begin
         sector = 3'd3;
         dd     = 6'(hue_ff - 9'd180);
      end else if (hue_ff >= 9'd120) begin
         sector = 3'd2;
         dd     = 6'(hue_ff - 9'd120);
      end else if (hue_ff >= 9'd60) begin
         sector = 3'd1;
         dd     = 6'(hue_ff - 9'd60);
      end else begin
         sector = 3'd0;
         dd     = 6'(hue_ff);
      end
      rd     = sector[0] ? 6'(7'd60 - 7'(dd)) : dd;
      rprod  = 10'(rd) * 10'd17;
      ramp   = rprod[9:2];
      unique case (sector)
         3'd0: hue_col = {8'd255, ramp, 8'd0};
         3'd1: hue_col = {ramp, 8'd255, 8'd0};
         3'd2: hue_col = {8'd0, 8'd255, ramp};
         3'd3: hue_col = {8'd0, ramp, 8'd255};
         3'd4: hue_col = {ramp, 8'd0, 8'd255};
         default: hue_col = {8'd255, 8'd0, ramp};
      endcase
   end

   // Chase distance and scaling; division by 25 is a multiply by 2622/65536.
   logic [NW:0]   chase_d_raw;
   logic [NW-1:0] chase_d;
   logic [4:0]    csq;
   logic [23:0]   chase_col;
   logic [11:0]   cr, cg, cb;
   logic [23:0]   cqr, cqg, cqb;
   always_comb begin
      chase_d_raw = {1'b0, head_ff} + {1'b0, n_eff} - {1'b0, idx_ff};
      chase_d = (chase_d_raw >= {1'b0, n_eff}) ? NW'(chase_d_raw - {1'b0, n_eff})
                                               : NW'(chase_d_raw);
      unique case (chase_d[2:0])
         3'd1: csq = 5'd16;
         3'd2: csq = 5'd9;
         3'd3: csq = 5'd4;
         default: csq = 5'd1;
      endcase
      cr  = 12'(base_ff[23:16]) * 12'(csq);
      cg  = 12'(base_ff[15:8])  * 12'(csq);
      cb  = 12'(base_ff[7:0])   * 12'(csq);
      cqr = 24'(cr) * 24'd2622;
      cqg = 24'(cg) * 24'd2622;
      cqb = 24'(cb) * 24'd2622;
      if (chase_d == '0) chase_col = base_ff;
      else if (32'(chase_d) <= 4)
         chase_col = {cqr[23:16], cqg[23:16], cqb[23:16]};
      else chase_col = 24'd0;
   end

   // Sparkle: the new LFSR value mod 100 comes from a reciprocal multiply,
   // and the fade by 4/5 divides by 5 through a multiply by 13108/65536.
   logic [15:0] lfsr_nx;
   logic [33:0] lq_prod;
   logic [9:0]  lq;
   logic [15:0] lq100;
   logic [15:0] lrem;
   logic        lit;
   logic [9:0]  sr, sg, sb;
   logic [23:0] sqr, sqg, sqb;
   logic [23:0] fade_col;
   always_comb begin
      lfsr_nx = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[15:1]};
      lq_prod = 34'(lfsr_nx) * 34'd167773;
      lq      = lq_prod[33:24];
      lq100   = 16'(lq) * 16'd100;
      lrem    = lfsr_nx - lq100;
      lit     = lrem < 16'd10;
      sr  = 10'(cur[23:16]) * 10'd4;
      sg  = 10'(cur[15:8])  * 10'd4;
      sb  = 10'(cur[7:0])   * 10'd4;
      sqr = 24'(sr) * 24'd13108;
      sqg = 24'(sg) * 24'd13108;
      sqb = 24'(sb) * 24'd13108;
      fade_col = {sqr[23:16], sqg[23:16], sqb[23:16]};
   end

   // Palette entry: (frame/30) mod count, taken from (frame/30) mod 12.
   logic [1:0]  cyc_sel;
   logic [23:0] pal_col;
   always_comb begin
      if (32'(pcnt) == 3) begin
         priority if (cyc_q_ff >= 4'd9) cyc_sel = 2'(cyc_q_ff - 4'd9);
         else if (cyc_q_ff >= 4'd6) cyc_sel = 2'(cyc_q_ff - 4'd6);
         else if (cyc_q_ff >= 4'd3) cyc_sel = 2'(cyc_q_ff - 4'd3);
         else cyc_sel = cyc_q_ff[1:0];
      end else if (32'(pcnt) == 2) begin
         cyc_sel = {1'b0, cyc_q_ff[0]};
      end else if (32'(pcnt) == 4) begin
         cyc_sel = cyc_q_ff[1:0];
      end else begin
         cyc_sel = 2'd0;
      end
      unique case (cyc_sel)
         2'd0: pal_col = pal_low_ff[23:0];
         2'd1: pal_col = pal_low_ff[47:24];
         2'd2: pal_col = pal_high_ff[23:0];
         default: pal_col = pal_high_ff[47:24];
      endcase
   end

   // New colour for the slot being written.
   always_comb begin
      unique case (mode_ff)
         MODE_RAINBOW: wr_data = hue_col;
         MODE_BREATH:  wr_data = breath_col_ff;
         MODE_CHASE:   wr_data = chase_col;
         MODE_SPARKLE: wr_data = lit ? base_ff : fade_col;
         default:      wr_data = (pcnt != '0) ? pal_col : cur;
      endcase
   end

   logic out_free;
   assign out_free = !out_v_ff || rsp_tready;
   assign mem_we   = (state_ff == ST_WRITE) && out_free;

   // Breathing colour for the frame.
   logic [6:0]  bk;
   logic [16:0] blev;
   logic [24:0] bpr, bpg, bpb;
   always_comb begin
      bk   = (br_ff < 7'd60) ? br_ff : 7'(7'd120 - br_ff);
      blev = BREATH_TABLE[11'(bk[5:0]) * 11'd17 +: 17];
      bpr  = 25'(base_ff[23:16]) * 25'(blev);
      bpg  = 25'(base_ff[15:8])  * 25'(blev);
      bpb  = 25'(base_ff[7:0])   * 25'(blev);
   end

   logic frame_go;
   assign frame_go = req_tvalid && req_tready && req_tdata[0] &&
                     mode_ff != MODE_STATIC && mode_ff != MODE_RSVD6 &&
                     mode_ff != MODE_RSVD7;

   // Slot walk sequencer and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         idx_ff     <= '0;
         bit_ff     <= '0;
         frame_ff   <= '0;
         lfsr_ff    <= LFSR_SEED;
         rb_off_ff  <= '0;
         br_ff      <= '0;
         head_ff    <= '0;
         cyc_sub_ff <= '0;
         cyc_q_ff   <= '0;
         valid_ff   <= '0;
         out_v_ff   <= 1'b0;
      end else begin
         if (mem_we) out_v_ff <= 1'b1;
         else if (rsp_tready) out_v_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (frame_go) begin
                  state_ff      <= ST_MOD;
                  bit_ff        <= 5'd31;
                  head_ff       <= '0;
                  hue_ff        <= rb_off_ff;
                  breath_col_ff <= {bpr[23:16], bpg[23:16], bpb[23:16]};
               end
            end
            ST_MOD: begin
               head_ff <= head_nx;
               if (bit_ff == 5'd0) state_ff <= ST_READ;
               else bit_ff <= 5'(bit_ff - 5'd1);
            end
            ST_READ: state_ff <= ST_WRITE;
            ST_WRITE: begin
               if (out_free) begin
                  out_slot_ff <= 5'(idx_ff);
                  out_col_ff  <= wr_data;
                  out_last_ff <= (idx_ff + NW'(1) == n_eff);
                  valid_ff[idx_addr] <= 1'b1;
                  if (mode_ff == MODE_SPARKLE) lfsr_ff <= lfsr_nx;
                  hue_ff <= (hue_ff + 9'd30 >= 9'd360) ? 9'(hue_ff + 9'd30 - 9'd360)
                                                      : 9'(hue_ff + 9'd30);
                  if (idx_ff + NW'(1) == n_eff) begin
                     state_ff <= ST_DRAIN;
                     frame_ff <= frame_ff + 32'd1;
                     // The frame count wraps to zero, and so do its residues.
                     if (frame_ff == 32'hFFFF_FFFF) begin
                        rb_off_ff  <= '0;
                        br_ff      <= '0;
                        cyc_sub_ff <= '0;
                        cyc_q_ff   <= '0;
                     end else begin
                        rb_off_ff <= (rb_off_ff == 9'd355) ? 9'd0 : 9'(rb_off_ff + 9'd5);
                        br_ff     <= (br_ff == 7'd119) ? 7'd0 : 7'(br_ff + 7'd1);
                        if (cyc_sub_ff == 5'd29) begin
                           cyc_sub_ff <= '0;
                           cyc_q_ff   <= (cyc_q_ff == 4'd11) ? 4'd0 : 4'(cyc_q_ff + 4'd1);
                        end else begin
                           cyc_sub_ff <= 5'(cyc_sub_ff + 5'd1);
                        end
                     end
                  end else begin
                     state_ff <= ST_READ;
                     idx_ff   <= idx_ff + NW'(1);
                  end
               end
            end
            default: if (out_free) state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSERT_CLK(a_write_only_walk, clock, reset, mem_we |-> state_ff == ST_WRITE, "bad write")
   `ASSERT_CLK(a_idx_range, clock, reset, state_ff != ST_IDLE |-> idx_ff < n_eff, "idx range")
   `ASSERT_CLK(a_no_accept_busy, clock, reset, state_ff != ST_IDLE |-> !req_tready, "busy")
   `ASSERT_CLK(a_out_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid, "drop")
endmodule

// ----- tb/sv/led_pattern_frame_generator_tb.sv -----
// ---------------------------------------------------------------------------
// LED pattern frame generator testbench
// Drives frame ticks through the request stream, predicts every slot colour
// of each frame with a behavioural model of the animation modes, and checks
// each response transfer against the oldest predicted slot. The run walks
// through several register settings and idling phases on both streams.
// ---------------------------------------------------------------------------
module led_pattern_frame_generator_tb;
   import lpfg_pkg::*;

   typedef struct packed {
      logic [4:0] slot;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } slot_colour_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr;
   logic [2:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   led_pattern_frame_generator i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_wr(csr_wr), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Model state and register copy.
   logic [2:0]  m_mode;
   logic [23:0] m_base;
   logic [5:0]  m_slots;
   logic [2:0]  m_pal_count;
   logic [47:0] m_pal_low;
   logic [47:0] m_pal_high;
   logic [31:0] m_frame;
   logic [23:0] m_leds [0:31];
   logic [15:0] m_lfsr;

   logic [7:0]      tick_queue [$];
   slot_colour_type colour_queue [$];
   int  sender_idle;
   int  receiver_stall;
   int  failures;
   longint cycles;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [23:0] scale_by(input logic [23:0] c, input int num,
                                            input int den);
      scale_by = {8'((int'(c[23:16]) * num) / den), 8'((int'(c[15:8]) * num) / den),
                  8'((int'(c[7:0]) * num) / den)};
   endfunction

   function automatic logic [23:0] hue_to_rgb(input int hue);
      int sector, d;
      logic [7:0] ramp;
      sector = hue / 60;
      d = hue % 60;
      ramp = (sector % 2 == 1) ? 8'(((60 - d) * 255) / 60) : 8'((d * 255) / 60);
      case (sector)
         0: hue_to_rgb = {8'd255, ramp, 8'd0};
         1: hue_to_rgb = {ramp, 8'd255, 8'd0};
         2: hue_to_rgb = {8'd0, 8'd255, ramp};
         3: hue_to_rgb = {8'd0, ramp, 8'd255};
         4: hue_to_rgb = {ramp, 8'd0, 8'd255};
         default: hue_to_rgb = {8'd255, 8'd0, ramp};
      endcase
   endfunction

   // Smoother-step brightness in Q1.16, evaluated exactly in integers.
   function automatic longint unsigned brightness(input int k);
      longint unsigned kk, k3, k4, k5, poly, num;
      kk = k;
      k3 = kk * kk * kk;
      k4 = k3 * kk;
      k5 = k4 * kk;
      poly = 6 * k5 + 36000 * k3 - 900 * k4;
      num = 64'd777600000 + 9 * poly;
      brightness = (num * 65536 + 64'd3888000000) / 64'd7776000000;
   endfunction

   // Work out one frame of slot colours for an accepted tick.
   task automatic predict_frame(input logic [7:0] data);
      int n, cnt, p, k, d;
      longint unsigned q;
      logic [23:0] c;
      logic fb;
      slot_colour_type item;
      if (!data[0] || m_mode == MODE_STATIC || m_mode > MODE_CYCLE) return;
      n = (m_slots == 0) ? 1 : (m_slots > 32 ? 32 : int'(m_slots));
      for (int i = 0; i < n; i++) begin
         case (m_mode)
            MODE_RAINBOW: m_leds[i] = hue_to_rgb((5 * int'(m_frame % 72) + 30 * (i % 12)) % 360);
            MODE_BREATH: begin
               p = m_frame % 120;
               k = (p < 60) ? p : 120 - p;
               q = brightness(k);
               m_leds[i] = {8'((m_base[23:16] * q) >> 16), 8'((m_base[15:8] * q) >> 16),
                            8'((m_base[7:0] * q) >> 16)};
            end
            MODE_CHASE: begin
               d = (int'(m_frame % n) + n - i) % n;
               if (d == 0) m_leds[i] = m_base;
               else if (d <= 4) m_leds[i] = scale_by(m_base, (5 - d) * (5 - d), 25);
               else m_leds[i] = 24'd0;
            end
            MODE_SPARKLE: begin
               fb = m_lfsr[0] ^ m_lfsr[2] ^ m_lfsr[3] ^ m_lfsr[5];
               m_lfsr = {fb, m_lfsr[15:1]};
               if (m_lfsr % 100 < 10) m_leds[i] = m_base;
               else m_leds[i] = scale_by(m_leds[i], 4, 5);
            end
            default: begin
               cnt = (m_pal_count > 4) ? 4 : int'(m_pal_count);
               if (cnt != 0) begin
                  case ((m_frame / 30) % cnt)
                     0: c = m_pal_low[23:0];
                     1: c = m_pal_low[47:24];
                     2: c = m_pal_high[23:0];
                     default: c = m_pal_high[47:24];
                  endcase
                  m_leds[i] = c;
               end
            end
         endcase
      end
      for (int i = 0; i < n; i++) begin
         item.slot = 5'(i);
         item.red = m_leds[i][23:16];
         item.green = m_leds[i][15:8];
         item.blue = m_leds[i][7:0];
         item.last = (i + 1 == n);
         colour_queue.push_back(item);
      end
      m_frame = m_frame + 1;
   endtask

   // Driver: offers the next pending tick, honouring the idle ratio.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'd0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) void'(tick_queue.pop_front());
         if (tick_queue.size() > 0 && $urandom_range(99) >= sender_idle) begin
            req_tvalid <= 1'b1;
            req_tdata <= tick_queue[0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: predicts on accepted ticks and checks each response transfer.
   always @(posedge clock) begin
      slot_colour_type want;
      cycles <= cycles + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall);
         if (req_tvalid && req_tready) predict_frame(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (colour_queue.size() == 0) begin
               $error("response transfer with no frame expected: %h", rsp_tdata);
               failures++;
            end else begin
               want = colour_queue.pop_front();
               if (rsp_tdata[4:0] !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_tdata[4:0]);
                  failures++;
               end
               if (rsp_tdata[12:5] !== want.red) begin
                  $error("red: expected %0d, got %0d", want.red, rsp_tdata[12:5]);
                  failures++;
               end
               if (rsp_tdata[20:13] !== want.green) begin
                  $error("green: expected %0d, got %0d", want.green, rsp_tdata[20:13]);
                  failures++;
               end
               if (rsp_tdata[28:21] !== want.blue) begin
                  $error("blue: expected %0d, got %0d", want.blue, rsp_tdata[28:21]);
                  failures++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_tlast);
                  failures++;
               end
            end
         end
      end
   end

   // Timeout guard.
   always @(posedge clock) begin
      if (cycles > 64'd900000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] index, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr <= 1'b0;
      case (index)
         REG_MODE: m_mode = value[2:0];
         REG_BASE: m_base = value[23:0];
         REG_SLOTS: m_slots = value[5:0];
         REG_PAL_COUNT: m_pal_count = value[2:0];
         REG_PAL_LOW: m_pal_low = value;
         REG_PAL_HIGH: m_pal_high = value;
         default: ;
      endcase
   endtask

   // Waits until every tick is taken and every slot colour has arrived.
   task automatic drain;
      while (tick_queue.size() != 0 || req_tvalid || colour_queue.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic setup(input logic [2:0] md, input logic [23:0] base, input logic [5:0] slots,
                        input logic [2:0] pcnt);
      write_reg(REG_MODE, 48'(md));
      write_reg(REG_BASE, 48'(base));
      write_reg(REG_SLOTS, 48'(slots));
      write_reg(REG_PAL_COUNT, 48'(pcnt));
      write_reg(REG_PAL_LOW, 48'({$urandom, $urandom}));
      write_reg(REG_PAL_HIGH, 48'({$urandom, $urandom}));
   endtask

   function automatic logic [5:0] random_slots;
      case ($urandom_range(9))
         0: random_slots = 6'd0;
         1: random_slots = 6'd1;
         2: random_slots = 6'(32 + $urandom_range(31));
         3: random_slots = 6'd32;
         default: random_slots = 6'($urandom_range(2, 12));
      endcase
   endfunction

   initial begin
      logic [2:0] md;
      reset = 1'b1;
      csr_wr = 1'b0;
      csr_index = REG_MODE;
      csr_wdata = '0;
      failures = 0;
      cycles = 0;
      sender_idle = 0;
      receiver_stall = 0;
      m_mode = MODE_STATIC;
      m_base = 24'd0;
      m_slots = 6'd32;
      m_pal_count = 3'd0;
      m_pal_low = '0;
      m_pal_high = '0;
      m_frame = 0;
      m_lfsr = LFSR_SEED;
      for (int i = 0; i < 32; i++) m_leds[i] = 24'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: static mode and a zero tick emit nothing; each mode at extremes.
      tick_queue.push_back(8'h01);
      tick_queue.push_back(8'hFE);
      drain();
      setup(MODE_CYCLE, 24'hFFFFFF, 6'd32, 3'd0);
      tick_queue.push_back(8'h01);
      drain();
      setup(MODE_RAINBOW, 24'hFFFFFF, 6'd63, 3'd7);
      repeat (2) tick_queue.push_back(8'h01);
      drain();
      setup(MODE_BREATH, 24'hFFFFFF, 6'd0, 3'd4);
      repeat (3) tick_queue.push_back(8'h01);
      drain();
      setup(MODE_CHASE, 24'h80FF01, 6'd7, 3'd1);
      repeat (3) tick_queue.push_back(8'h01);
      drain();
      setup(MODE_SPARKLE, 24'hFFFFFF, 6'd32, 3'd2);
      repeat (3) tick_queue.push_back(8'h01);
      drain();
      setup(MODE_CYCLE, 24'h000000, 6'd1, 3'd4);
      repeat (3) tick_queue.push_back(8'h01);
      drain();
      setup(MODE_RSVD6, 24'h123456, 6'd5, 3'd3);
      tick_queue.push_back(8'h01);
      drain();
      write_reg(REG_MODE, 48'(MODE_RSVD7));
      tick_queue.push_back(8'h01);
      drain();

      // Random phases: each picks a setting and an idling pattern.
      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 4)
            0: begin sender_idle = 0; receiver_stall = 0; end
            1: begin sender_idle = 74; receiver_stall = 0; end
            2: begin sender_idle = 0; receiver_stall = 74; end
            default: begin sender_idle = 27; receiver_stall = 27; end
         endcase
         md = 3'($urandom_range(1, 5));
         if ($urandom_range(9) == 0) md = 3'($urandom_range(7));
         setup(md, 24'($urandom), random_slots(), 3'($urandom_range(7)));
         for (int t = 0; t < 20; t++) begin
            // Mostly real ticks, with some idle words carrying random upper bits.
            tick_queue.push_back({7'($urandom), ($urandom_range(9) != 0)});
            if (t == 10) begin
               // Hold off until the block has delivered everything so far.
               while (tick_queue.size() != 0 || req_tvalid || colour_queue.size() != 0)
                  @(posedge clock);
            end
         end
         drain();
      end

      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
